// ----- src/pip_pkg.sv -----
`timescale 1ns / 1ps
// Shared definitions for the point-in-polygon test core.
// Holds default sizes, item kind codes and the operation type used by front and back.
package pip_pkg;

    localparam int MAX_EDGES_DEF   = 64;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int TOL_W           = 16;
    localparam int MIN_EDGES       = 3;
    localparam int QDEPTH          = 2;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } q_status_t;

endpackage

// ----- src/pip_front.sv -----
`timescale 1ns / 1ps
// Front end of the point-in-polygon test core: takes items, classifies them
// and holds them in a two-entry queue for the back end. Depends on pip_pkg.
module pip_front
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [1:0]               kind,
    input  logic [FIELD_W-1:0]       start_x,
    input  logic [FIELD_W-1:0]       start_y,
    input  logic [FIELD_W-1:0]       end_x,
    input  logic [FIELD_W-1:0]       end_y,
    input  logic [FIELD_W-1:0]       point_x,
    input  logic [FIELD_W-1:0]       point_y,
    output logic                     busy,
    output q_status_t                q_status,
    output logic [4*COORD_WIDTH-1:0] q_coords,
    input  logic                     q_pop
);

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int FW  = $clog2(QDEPTH + 1);

    logic [FW-1:0]      fill_reg;
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    op_t                op_mem_reg  [QDEPTH];
    logic [4*CW-1:0]    crd_mem_reg [QDEPTH];

    op_t                op_next;
    logic               known;
    logic [4*CW-1:0]    crd_next;
    logic               push;
    logic               pop;

    always_comb
    begin
        known    = 1'b1;
        op_next  = OP_QUERY;
        crd_next = {point_x[CW-1:0], point_y[CW-1:0], {(2*CW){1'b0}}};
        case (kind)
            KIND_CLEAR:
            begin
                op_next = OP_CLEAR;
            end
            KIND_ADD:
            begin
                op_next  = OP_ADD;
                crd_next = {start_x[CW-1:0], start_y[CW-1:0],
                            end_x[CW-1:0], end_y[CW-1:0]};
            end
            KIND_QUERY:
            begin
                op_next = OP_QUERY;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    assign busy = (fill_reg == FW'(QDEPTH));
    assign push = start && !busy && known;
    assign pop  = q_pop && (fill_reg != '0);

    assign q_status.valid = (fill_reg != '0);
    assign q_status.op    = op_mem_reg[rd_ptr_reg];
    assign q_coords       = crd_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem_reg[wr_ptr_reg]  <= op_next;
            crd_mem_reg[wr_ptr_reg] <= crd_next;
        end
    end

endmodule

// ----- src/pip_back.sv -----
`timescale 1ns / 1ps
// Back end of the point-in-polygon test core: edge table memory, edge count,
// overflow flag, tolerance register and the pipelined ray-crossing scan. Depends on pip_pkg.
module pip_back
    import pip_pkg::*;
#(
    parameter int MAX_EDGES   = MAX_EDGES_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [TOL_W-1:0]         cfg_wdata,
    input  q_status_t                q_status,
    input  logic [4*COORD_WIDTH-1:0] q_coords,
    output logic                     q_pop,
    output logic                     done,
    output logic                     inside_res,
    output logic                     on_boundary,
    output logic                     too_few_edges,
    output logic                     table_overflow
);

    localparam int CW   = COORD_WIDTH;
    localparam int AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNTW = $clog2(MAX_EDGES + 1);
    localparam int CMPW = (CW + 1 > TOL_W) ? CW + 1 : TOL_W;
    localparam int PRW  = 2 * CW + 2;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t                 state_reg;
    logic [CNTW-1:0]        cnt_reg;
    logic                   ovf_reg;
    logic [TOL_W-1:0]       tol_reg;
    logic [CNTW-1:0]        idx_reg;
    logic                   v1_reg;
    logic                   v2_reg;
    logic                   v3_reg;
    logic                   parity_reg;
    logic                   onb_reg;
    logic                   done_reg;
    logic                   inside_reg;
    logic                   onbnd_reg;
    logic                   few_reg;
    logic                   ovfo_reg;

    logic [4*CW-1:0]        mem [MAX_EDGES];
    logic [4*CW-1:0]        rd_data_reg;
    logic signed [CW-1:0]   px_reg;
    logic signed [CW-1:0]   py_reg;

    logic signed [CW:0]     a_reg;
    logic signed [CW:0]     b_reg;
    logic signed [CW:0]     c_reg;
    logic signed [CW:0]     d_reg;
    logic                   cross2_reg;
    logic                   hit2_reg;
    logic signed [PRW-1:0]  pl_reg;
    logic signed [PRW-1:0]  pr_reg;
    logic                   cross3_reg;
    logic                   hit3_reg;

    logic                   issue;
    logic                   room;
    logic signed [CW-1:0]   sx;
    logic signed [CW-1:0]   sy;
    logic signed [CW-1:0]   ex;
    logic signed [CW-1:0]   ey;
    logic signed [CW:0]     den;
    logic signed [CW:0]     num;
    logic signed [CW:0]     dys;
    logic [CW:0]            abs_e;
    logic [CW:0]            abs_s;
    logic signed [CW-1:0]   lo;
    logic signed [CW-1:0]   hi;
    logic signed [CW:0]     a_next;
    logic signed [CW:0]     b_next;
    logic signed [CW:0]     c_next;
    logic signed [CW:0]     d_next;
    logic                   cross_next;
    logic                   hit_next;
    logic signed [PRW-1:0]  pl_next;
    logic signed [PRW-1:0]  pr_next;

    assign q_pop = (state_reg == ST_IDLE) && q_status.valid;
    assign issue = (state_reg == ST_SCAN) && (idx_reg < cnt_reg);
    assign room  = (cnt_reg < CNTW'(MAX_EDGES));

    always_comb
    begin
        sx  = rd_data_reg[4*CW-1:3*CW];
        sy  = rd_data_reg[3*CW-1:2*CW];
        ex  = rd_data_reg[2*CW-1:CW];
        ey  = rd_data_reg[CW-1:0];
        cross_next = ((py_reg > ey) && (py_reg <= sy)) || ((py_reg > sy) && (py_reg <= ey));
        den = (CW + 1)'(sy) - (CW + 1)'(ey);
        num = (CW + 1)'(py_reg) - (CW + 1)'(ey);
        dys = (CW + 1)'(py_reg) - (CW + 1)'(sy);
        abs_e = (num < 0) ? (CW + 1)'(-num) : (CW + 1)'(num);
        abs_s = (dys < 0) ? (CW + 1)'(-dys) : (CW + 1)'(dys);
        lo  = (sx < ex) ? sx : ex;
        hi  = (sx < ex) ? ex : sx;
        hit_next = (CMPW'(abs_e) <= CMPW'(tol_reg)) && (CMPW'(abs_s) <= CMPW'(tol_reg))
                   && (px_reg >= lo) && (px_reg <= hi);
        a_next = (den < 0) ? -num : num;
        d_next = (den < 0) ? -den : den;
        b_next = (CW + 1)'(sx) - (CW + 1)'(ex);
        c_next = (CW + 1)'(px_reg) - (CW + 1)'(ex);
        pl_next = PRW'(a_reg) * PRW'(b_reg);
        pr_next = PRW'(c_reg) * PRW'(d_reg);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && (q_status.op == OP_ADD) && room)
        begin
            mem[cnt_reg[AW-1:0]] <= q_coords;
        end
        if (issue)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && (q_status.op == OP_QUERY))
        begin
            px_reg <= q_coords[4*CW-1:3*CW];
            py_reg <= q_coords[3*CW-1:2*CW];
        end
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        cross2_reg <= cross_next;
        hit2_reg   <= hit_next;
        pl_reg     <= pl_next;
        pr_reg     <= pr_next;
        cross3_reg <= cross2_reg;
        hit3_reg   <= hit2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            tol_reg    <= '0;
            idx_reg    <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            parity_reg <= 1'b0;
            onb_reg    <= 1'b0;
            done_reg   <= 1'b0;
            inside_reg <= 1'b0;
            onbnd_reg  <= 1'b0;
            few_reg    <= 1'b0;
            ovfo_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            done_reg <= 1'b0;
            v1_reg   <= issue;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            if (v3_reg)
            begin
                if (cross3_reg && (pl_reg < pr_reg))
                begin
                    parity_reg <= !parity_reg;
                end
                if (hit3_reg)
                begin
                    onb_reg <= 1'b1;
                end
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_status.valid)
                    begin
                        case (q_status.op)
                            OP_CLEAR:
                            begin
                                cnt_reg <= '0;
                                ovf_reg <= 1'b0;
                            end
                            OP_ADD:
                            begin
                                if (room)
                                begin
                                    cnt_reg <= cnt_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            OP_QUERY:
                            begin
                                idx_reg    <= '0;
                                parity_reg <= 1'b0;
                                onb_reg    <= 1'b0;
                                state_reg  <= ST_SCAN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (issue)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!v1_reg && !v2_reg && !v3_reg)
                    begin
                        done_reg   <= 1'b1;
                        inside_reg <= onb_reg || parity_reg;
                        onbnd_reg  <= onb_reg;
                        few_reg    <= (cnt_reg < CNTW'(MIN_EDGES));
                        ovfo_reg   <= ovf_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done           = done_reg;
    assign inside_res     = inside_reg;
    assign on_boundary    = onbnd_reg;
    assign too_few_edges  = few_reg;
    assign table_overflow = ovfo_reg;

endmodule

// ----- src/point_in_polygon_test_core.sv -----
`timescale 1ns / 1ps
// Top level of the point-in-polygon test core.
// Instantiates pip_front and pip_back; depends on pip_pkg.
//
// Items of a known kind are taken when start is high and busy is low; busy rises
// only when two items wait in the queue between the front and back ends. Clear
// and add items give no result. A query reads one stored edge per cycle from the
// edge table memory into the three-stage crossing pipeline. Its result is on
// done for exactly one cycle, once the edge scan and the pipeline have drained;
// the back end takes no new item from the queue until then. Results cannot be
// held off: the receiver must take every transfer on done.
module point_in_polygon_test_core
    import pip_pkg::*;
#(
    parameter int MAX_EDGES   = MAX_EDGES_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [TOL_W-1:0]   cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [FIELD_W-1:0] start_x,
    input  logic [FIELD_W-1:0] start_y,
    input  logic [FIELD_W-1:0] end_x,
    input  logic [FIELD_W-1:0] end_y,
    input  logic [FIELD_W-1:0] point_x,
    input  logic [FIELD_W-1:0] point_y,
    output logic               done,
    output logic               inside_res,
    output logic               on_boundary,
    output logic               too_few_edges,
    output logic               table_overflow
);

    q_status_t                 q_status;
    logic [4*COORD_WIDTH-1:0]  q_coords;
    logic                      q_pop;

    pip_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .kind     (kind),
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x    (end_x),
        .end_y    (end_y),
        .point_x  (point_x),
        .point_y  (point_y),
        .busy     (busy),
        .q_status (q_status),
        .q_coords (q_coords),
        .q_pop    (q_pop)
    );

    pip_back #(
        .MAX_EDGES   (MAX_EDGES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .q_status       (q_status),
        .q_coords       (q_coords),
        .q_pop          (q_pop),
        .done           (done),
        .inside_res     (inside_res),
        .on_boundary    (on_boundary),
        .too_few_edges  (too_few_edges),
        .table_overflow (table_overflow)
    );

endmodule
